// File: src/ideal_gas_cons_to_prim_assert.svh
// Assertion macros shared by the RTL of the conserved-to-primitive block.
`ifndef IDEAL_GAS_CONS_TO_PRIM_ASSERT_SVH
`define IDEAL_GAS_CONS_TO_PRIM_ASSERT_SVH

// Implication in the same cycle, disabled while reset is asserted.
`define IGC_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("implication check failed");

// Implication in the next cycle, also checked across reset.
`define IGC_ASSERT_NEXT(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// File: src/igc_pkg.sv
`default_nettype none
package igc_pkg;
    localparam int FRAC_BITS_DEF = 16;
    localparam int WORD_W        = 32;
    localparam int DENS_W        = 31;
    localparam int GAMMA_W       = 18;
    // Quotient bits kept by each divider; larger quotients saturate anyway.
    localparam int QUO_BITS      = 34;
    localparam logic [GAMMA_W-1:0] GAMMA_ONE   = 18'd65536;
    localparam logic [GAMMA_W-1:0] GAMMA_RESET = 18'd109227;

    typedef struct packed {
        logic [WORD_W-1:0] etot;
        logic [2:0]        neg;
    } side_t;
endpackage
`default_nettype wire

// File: src/igc_div.sv
`default_nettype none
module igc_div #(
    parameter int NUM_W    = 48,
    parameter int DEN_W    = 31,
    parameter int QUO_BITS = 34
) (
    input  wire logic                aclk,
    input  wire logic                en,
    input  wire logic [NUM_W-1:0]    num_in,
    input  wire logic [DEN_W-1:0]    den_in,
    output logic      [QUO_BITS-1:0] quo_out,
    output logic                     ovf_out
);
    localparam int HI_W  = NUM_W - QUO_BITS;
    localparam int CMP_W = (HI_W > DEN_W) ? HI_W : DEN_W;

    logic [DEN_W-1:0]    rem_reg [0:QUO_BITS];
    logic [NUM_W-1:0]    num_reg [0:QUO_BITS];
    logic [DEN_W-1:0]    den_reg [0:QUO_BITS];
    logic [QUO_BITS-1:0] quo_reg [0:QUO_BITS];
    logic                ovf_reg [0:QUO_BITS];

    logic [CMP_W-1:0] hi_ext;
    logic [CMP_W-1:0] den_ext;

    assign hi_ext  = CMP_W'(num_in[NUM_W-1:QUO_BITS]);
    assign den_ext = CMP_W'(den_in);

    // Entry stage: the upper part of the numerator is the first partial remainder.
    // If it already reaches the divisor, the quotient does not fit and saturates.
    always_ff @(posedge aclk) begin
        if (en) begin
            ovf_reg[0] <= hi_ext >= den_ext;
            rem_reg[0] <= hi_ext[DEN_W-1:0];
            num_reg[0] <= num_in;
            den_reg[0] <= den_in;
            quo_reg[0] <= '0;
        end
    end

    for (genvar j = 0; j < QUO_BITS; j++) begin : g_step
        logic [DEN_W:0]   trial;
        logic [DEN_W:0]   diff;
        logic             ge;

        assign trial = {rem_reg[j], num_reg[j][QUO_BITS-1-j]};
        assign diff  = trial - {1'b0, den_reg[j]};
        assign ge    = trial >= {1'b0, den_reg[j]};

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[j+1] <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
                quo_reg[j+1] <= {quo_reg[j][QUO_BITS-2:0], ge};
                num_reg[j+1] <= num_reg[j];
                den_reg[j+1] <= den_reg[j];
                ovf_reg[j+1] <= ovf_reg[j];
            end
        end
    end

    assign quo_out = quo_reg[QUO_BITS];
    assign ovf_out = ovf_reg[QUO_BITS];
endmodule
`default_nettype wire

// File: src/ideal_gas_cons_to_prim.sv
// From input transaction to result, data passes the front-end stages, the divider rows and the output stages.
// Throughput: one transaction per cycle while the pipeline advances; each divider is a row of 34 restoring stages.
// The whole pipeline advances while the output register is empty or taken.
// Synchronous active-low reset clears all valid bits and sets gamma to about 5/3.
`default_nettype none
module ideal_gas_cons_to_prim #(
    parameter int FRAC_BITS = igc_pkg::FRAC_BITS_DEF
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        cfg_wr_en,
    input  wire logic [igc_pkg::GAMMA_W-1:0] cfg_wr_data,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire logic [igc_pkg::DENS_W-1:0]  s_density,
    input  wire logic [igc_pkg::WORD_W-1:0]  s_momentum_x,
    input  wire logic [igc_pkg::WORD_W-1:0]  s_momentum_y,
    input  wire logic [igc_pkg::WORD_W-1:0]  s_momentum_z,
    input  wire logic [igc_pkg::WORD_W-1:0]  s_total_energy,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic [igc_pkg::WORD_W-1:0]       m_pressure,
    output logic [igc_pkg::WORD_W-1:0]       m_internal_energy,
    output logic [igc_pkg::WORD_W-1:0]       m_velocity_x,
    output logic [igc_pkg::WORD_W-1:0]       m_velocity_y,
    output logic [igc_pkg::WORD_W-1:0]       m_velocity_z
);
    import igc_pkg::*;
    `include "ideal_gas_cons_to_prim_assert.svh"

    localparam int NSTAGE = QUO_BITS + 7;
    localparam int VNUM_W = WORD_W + FRAC_BITS;
    localparam int PROD_W = GAMMA_W + 1 + WORD_W;

    localparam logic [WORD_W-1:0] SAT_MAX = {1'b0, {(WORD_W-1){1'b1}}};
    localparam logic [WORD_W-1:0] SAT_MIN = {1'b1, {(WORD_W-1){1'b0}}};

    logic                 adv;
    logic [NSTAGE-1:0]    vld_reg;
    logic [GAMMA_W-1:0]   gamma_reg;

    logic [WORD_W-1:0]    mom [0:2];

    logic [DENS_W-1:0]    a_d_reg;
    logic [WORD_W-1:0]    a_mag_reg [0:2];
    side_t                a_side_reg;

    logic [2*WORD_W-1:0]  b_sq_reg [0:2];
    logic [DENS_W-1:0]    b_d_reg;
    logic [WORD_W-1:0]    b_mag_reg [0:2];
    side_t                b_side_reg;

    logic [2*WORD_W-1:0]  c_sum_reg;
    logic [DENS_W-1:0]    c_d_reg;
    logic [VNUM_W-1:0]    c_vnum_reg [0:2];
    side_t                c_side_reg;

    side_t                sd_reg [0:QUO_BITS];

    logic [QUO_BITS-1:0]  ek_q;
    logic                 ek_ovf;
    logic [QUO_BITS-1:0]  v_q [0:2];
    logic                 v_ovf [0:2];

    logic [WORD_W+2:0]    ei_diff;
    logic [WORD_W-1:0]    ei_next;
    logic [WORD_W-1:0]    vel_next [0:2];

    logic [WORD_W-1:0]    e_ei_reg;
    logic [WORD_W-1:0]    e_vel_reg [0:2];
    logic signed [PROD_W-1:0] f_prod_reg;
    logic [WORD_W-1:0]    f_ei_reg;
    logic [WORD_W-1:0]    f_vel_reg [0:2];

    logic signed [GAMMA_W:0]  gm1;
    logic signed [PROD_W-1:0] p_adj;
    logic signed [PROD_W-17:0] p_shift;
    logic [WORD_W-1:0]    p_next;

    logic [WORD_W-1:0]    pres_reg;
    logic [WORD_W-1:0]    ie_reg;
    logic [WORD_W-1:0]    vel_reg [0:2];

    assign adv     = !vld_reg[NSTAGE-1] || m_ready;
    assign s_ready = adv;
    assign mom[0]  = s_momentum_x;
    assign mom[1]  = s_momentum_y;
    assign mom[2]  = s_momentum_z;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gamma_reg <= GAMMA_RESET;
            vld_reg   <= '0;
        end else begin
            if (cfg_wr_en) begin
                gamma_reg <= cfg_wr_data;
            end
            if (adv) begin
                vld_reg <= {vld_reg[NSTAGE-2:0], s_valid};
            end
        end
    end

    // Front end: magnitudes, squares, sum of squares and divider operands; a zero density is replaced by one.
    always_ff @(posedge aclk) begin
        if (adv) begin
            a_d_reg         <= (s_density == '0) ? DENS_W'(1) : s_density;
            a_side_reg.etot <= s_total_energy;
            for (int i = 0; i < 3; i++) begin
                a_side_reg.neg[i] <= mom[i][WORD_W-1];
                a_mag_reg[i]      <= mom[i][WORD_W-1] ? (~mom[i] + 1'b1) : mom[i];
            end
            b_d_reg    <= a_d_reg;
            b_side_reg <= a_side_reg;
            for (int i = 0; i < 3; i++) begin
                b_sq_reg[i]  <= 64'(a_mag_reg[i]) * 64'(a_mag_reg[i]);
                b_mag_reg[i] <= a_mag_reg[i];
            end
            c_sum_reg  <= b_sq_reg[0] + b_sq_reg[1] + b_sq_reg[2];
            c_d_reg    <= b_d_reg;
            c_side_reg <= b_side_reg;
            for (int i = 0; i < 3; i++) begin
                c_vnum_reg[i] <= {b_mag_reg[i], {FRAC_BITS{1'b0}}};
            end
        end
    end

    // Kinetic energy is the sum of squares over twice the density.
    igc_div #(.NUM_W(2*WORD_W), .DEN_W(WORD_W), .QUO_BITS(QUO_BITS)) u_div_ek (
        .aclk    (aclk),
        .en      (adv),
        .num_in  (c_sum_reg),
        .den_in  ({c_d_reg, 1'b0}),
        .quo_out (ek_q),
        .ovf_out (ek_ovf)
    );

    for (genvar c = 0; c < 3; c++) begin : g_vel
        igc_div #(.NUM_W(VNUM_W), .DEN_W(DENS_W), .QUO_BITS(QUO_BITS)) u_div_v (
            .aclk    (aclk),
            .en      (adv),
            .num_in  (c_vnum_reg[c]),
            .den_in  (c_d_reg),
            .quo_out (v_q[c]),
            .ovf_out (v_ovf[c])
        );
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            sd_reg[0] <= c_side_reg;
            for (int i = 1; i <= QUO_BITS; i++) begin
                sd_reg[i] <= sd_reg[i-1];
            end
        end
    end

    // A kinetic energy of 2^33 or more drives internal energy to the floor.
    always_comb begin
        ei_diff = {{3{sd_reg[QUO_BITS].etot[WORD_W-1]}}, sd_reg[QUO_BITS].etot}
                  - {2'b00, ek_q[WORD_W:0]};
        if (ek_ovf || ek_q[QUO_BITS-1]) begin
            ei_next = SAT_MIN;
        end else if (ei_diff[WORD_W+2:WORD_W-1] != {4{ei_diff[WORD_W+2]}}) begin
            ei_next = ei_diff[WORD_W+2] ? SAT_MIN : SAT_MAX;
        end else begin
            ei_next = ei_diff[WORD_W-1:0];
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            logic [WORD_W-1:0] mag;
            mag = (v_ovf[i] || (v_q[i] > QUO_BITS'(SAT_MIN))) ? SAT_MIN : v_q[i][WORD_W-1:0];
            if (sd_reg[QUO_BITS].neg[i]) begin
                vel_next[i] = ~mag + 1'b1;
            end else begin
                vel_next[i] = mag[WORD_W-1] ? SAT_MAX : mag;
            end
        end
    end

    assign gm1 = $signed({1'b0, gamma_reg}) - $signed({1'b0, GAMMA_ONE});

    // Pressure rounds toward zero: bias negative products before the shift.
    assign p_adj   = f_prod_reg + (f_prod_reg[PROD_W-1] ? PROD_W'(65535) : PROD_W'(0));
    assign p_shift = p_adj[PROD_W-1:16];
    always_comb begin
        if (p_shift[PROD_W-17:WORD_W-1] != {(PROD_W-16-WORD_W+1){p_shift[PROD_W-17]}}) begin
            p_next = p_shift[PROD_W-17] ? SAT_MIN : SAT_MAX;
        end else begin
            p_next = p_shift[WORD_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            e_ei_reg   <= ei_next;
            f_prod_reg <= PROD_W'(gm1) * PROD_W'($signed(e_ei_reg));
            f_ei_reg   <= e_ei_reg;
            pres_reg   <= p_next;
            ie_reg     <= f_ei_reg;
            for (int i = 0; i < 3; i++) begin
                e_vel_reg[i] <= vel_next[i];
                f_vel_reg[i] <= e_vel_reg[i];
                vel_reg[i]   <= f_vel_reg[i];
            end
        end
    end

    assign m_valid           = vld_reg[NSTAGE-1];
    assign m_pressure        = pres_reg;
    assign m_internal_energy = ie_reg;
    assign m_velocity_x      = vel_reg[0];
    assign m_velocity_y      = vel_reg[1];
    assign m_velocity_z      = vel_reg[2];

    `IGC_ASSERT_NEXT(a_reset_empty, aclk, !aresetn, !m_valid)
    `IGC_ASSERT_IMP(a_zero_ei_zero_p, aclk, aresetn,
        m_valid && (m_internal_energy == '0), m_pressure == '0)
    `IGC_ASSERT_IMP(a_unit_gamma, aclk, aresetn,
        m_valid && (gamma_reg == GAMMA_ONE) && $stable(gamma_reg), m_pressure == '0)
endmodule
`default_nettype wire
